>>> src/assert_macros.svh
// assertion macros used by the top-level core
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ndt_pkg.sv
// package for the transpose address generator: codes, config bundle, axis check
// no dependencies
`timescale 1ns / 1ps

package ndt_pkg;

    localparam int NUM_CFG_SIZES = 4;
    localparam int CFG_SIZE_W    = 16;
    localparam int CFG_DIMS_W    = 3;
    localparam int ORDER_W       = 8;
    localparam int AXIS_W        = 3;
    localparam int DIM_LIMIT     = 8;
    localparam int NDIM_W        = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int VALUE_W       = 64;
    localparam int STATUS_W      = 2;

    localparam int DEF_MAX_DIMS     = 4;
    localparam int DEF_DIM_WIDTH    = 16;
    localparam int DEF_OFFSET_WIDTH = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ORDER = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DIMS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AXIS_OOR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP_AXIS = 2'd3;

    typedef struct packed {
        logic [CFG_DIMS_W-1:0]                     num_dims;
        logic [NUM_CFG_SIZES-1:0][CFG_SIZE_W-1:0]  dim_size;
        logic [ORDER_W-1:0]                        axis_order;
    } ndt_cfg_t;

    // source axis taken by output axis j
    function automatic logic [AXIS_W-1:0] axis_of(input logic [ORDER_W-1:0] order,
                                                  input logic [NDIM_W-1:0] j);
        logic [AXIS_W-1:0] r;
        r = '0;
        if (j < NDIM_W'(4))
            r = {1'b0, order[2*j[1:0] +: 2]};
        return r;
    endfunction

    // configuration check, priority no dims, out of range, duplicate
    function automatic logic [STATUS_W-1:0] check_cfg(input logic [ORDER_W-1:0] order,
                                                      input logic [NDIM_W-1:0] n);
        logic [STATUS_W-1:0]  err;
        logic [DIM_LIMIT-1:0] seen;
        logic                 oor;
        logic                 dup;
        logic [AXIS_W-1:0]    a;
        err  = ST_OK;
        seen = '0;
        oor  = 1'b0;
        dup  = 1'b0;
        for (int j = 0; j < DIM_LIMIT; j++)
        begin
            a = axis_of(order, NDIM_W'(j));
            if (NDIM_W'(j) < n)
            begin
                if ({1'b0, a} >= n)
                    oor = 1'b1;
                if (seen[a])
                    dup = 1'b1;
                seen[a] = 1'b1;
            end
        end
        if (n == '0)
            err = ST_NO_DIMS;
        else if (oor)
            err = ST_AXIS_OOR;
        else if (dup)
            err = ST_DUP_AXIS;
        return err;
    endfunction

endpackage

>>> src/ndt_front.sv
// front: two-entry queue of element beats ahead of the address engine
// depends on ndt_pkg
`timescale 1ns / 1ps

module ndt_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ndt_pkg::VALUE_W-1:0] element_value,
    output logic                        q_valid,
    input  logic                        q_pop,
    output logic [ndt_pkg::VALUE_W-1:0] q_value
);
    import ndt_pkg::*;

    logic [1:0][VALUE_W-1:0] mem_reg;
    logic                    wr_ptr_reg;
    logic                    wr_ptr_next;
    logic                    rd_ptr_reg;
    logic                    rd_ptr_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic                    push;
    logic                    pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_value  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= element_value;
    end

endmodule

>>> src/ndt_engine.sv
// back end: pass setup (check, strides, step deltas) and per-beat address step
// depends on ndt_pkg
`timescale 1ns / 1ps

module ndt_engine
#(
    parameter int MAX_DIMS     = ndt_pkg::DEF_MAX_DIMS,
    parameter int DIM_WIDTH    = ndt_pkg::DEF_DIM_WIDTH,
    parameter int OFFSET_WIDTH = ndt_pkg::DEF_OFFSET_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ndt_pkg::ndt_cfg_t            cfg,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  logic [ndt_pkg::VALUE_W-1:0]  q_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [OFFSET_WIDTH-1:0]      target_offset,
    output logic [ndt_pkg::VALUE_W-1:0]  out_value,
    output logic [ndt_pkg::STATUS_W-1:0] status,
    output logic                         last
);
    import ndt_pkg::*;

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W = $clog2(MAX_DIMS + 1);
    localparam int PROD_W = OFFSET_WIDTH + DIM_WIDTH;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STRIDE = 2'd1;
    localparam logic [1:0] S_DELTA  = 2'd2;
    localparam logic [1:0] S_RUN    = 2'd3;

    logic [1:0]                                state_reg;
    logic [1:0]                                state_next;
    logic [CNT_W-1:0]                          n_reg;
    logic [ORDER_W-1:0]                        order_reg;
    logic [STATUS_W-1:0]                       err_reg;
    logic [CNT_W-1:0]                          step_reg;
    logic [OFFSET_WIDTH-1:0]                   run_reg;
    logic [OFFSET_WIDTH-1:0]                   suf_reg;
    logic [OFFSET_WIDTH-1:0]                   offset_reg;
    logic [MAX_DIMS-1:0][DIM_WIDTH-1:0]        size_reg;
    logic [MAX_DIMS-1:0][DIM_WIDTH-1:0]        cnt_reg;
    logic [MAX_DIMS-1:0][OFFSET_WIDTH-1:0]     stride_reg;
    logic [MAX_DIMS-1:0][OFFSET_WIDTH-1:0]     span_reg;
    logic [MAX_DIMS-1:0][OFFSET_WIDTH-1:0]     delta_reg;
    logic                                      out_valid_reg;
    logic [OFFSET_WIDTH-1:0]                   out_offset_reg;
    logic [VALUE_W-1:0]                        out_value_reg;
    logic [STATUS_W-1:0]                       out_status_reg;
    logic                                      out_last_reg;

    logic [CNT_W-1:0]                          n_sat;
    logic [MAX_DIMS-1:0][DIM_WIDTH-1:0]        size_in;
    logic [IDX_W-1:0]                          ax_idx;
    logic [IDX_W-1:0]                          k_idx;
    logic [PROD_W-1:0]                         prod;
    logic                                      out_free;
    logic                                      fire;
    logic                                      hit;
    logic [IDX_W-1:0]                          hit_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = (state_reg == S_RUN) && q_valid && out_free;
    assign q_pop    = fire;

    always_comb
    begin
        if ({1'b0, cfg.num_dims} > (CFG_DIMS_W + 1)'(MAX_DIMS))
            n_sat = CNT_W'(MAX_DIMS);
        else
            n_sat = CNT_W'(cfg.num_dims);
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (i < NUM_CFG_SIZES)
                size_in[i] = DIM_WIDTH'(cfg.dim_size[i]);
            else
                size_in[i] = DIM_WIDTH'(1);
            if (size_in[i] == '0)
                size_in[i] = DIM_WIDTH'(1);
        end
        ax_idx = IDX_W'(axis_of(order_reg, NDIM_W'(step_reg - CNT_W'(1))));
        k_idx  = IDX_W'(step_reg - CNT_W'(1));
        prod   = PROD_W'(run_reg) * PROD_W'(size_reg[ax_idx]);
        // innermost axis in use that still has room to count
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (CNT_W'(i) < n_reg
                && ({1'b0, cnt_reg[i]} + (DIM_WIDTH + 1)'(1)) < {1'b0, size_reg[i]})
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (check_cfg(cfg.axis_order, NDIM_W'(n_sat)) == ST_OK)
                        state_next = S_STRIDE;
                    else
                        state_next = S_RUN;
                end
            end
            S_STRIDE:
            begin
                if (step_reg == '0)
                    state_next = S_DELTA;
            end
            S_DELTA:
            begin
                if (step_reg == '0)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (fire && (err_reg != ST_OK || !hit))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            order_reg     <= '0;
            err_reg       <= ST_OK;
            step_reg      <= '0;
            run_reg       <= '0;
            suf_reg       <= '0;
            offset_reg    <= '0;
            size_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
                out_valid_reg <= fire;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        n_reg      <= n_sat;
                        order_reg  <= cfg.axis_order;
                        err_reg    <= check_cfg(cfg.axis_order, NDIM_W'(n_sat));
                        size_reg   <= size_in;
                        cnt_reg    <= '0;
                        offset_reg <= '0;
                        step_reg   <= n_sat;
                        run_reg    <= OFFSET_WIDTH'(1);
                    end
                end
                S_STRIDE:
                begin
                    if (step_reg == '0)
                    begin
                        step_reg <= n_reg;
                        suf_reg  <= '0;
                    end
                    else
                    begin
                        run_reg  <= OFFSET_WIDTH'(prod);
                        step_reg <= step_reg - CNT_W'(1);
                    end
                end
                S_DELTA:
                begin
                    if (step_reg != '0)
                    begin
                        suf_reg  <= suf_reg + span_reg[k_idx] - stride_reg[k_idx];
                        step_reg <= step_reg - CNT_W'(1);
                    end
                end
                S_RUN:
                begin
                    if (fire && err_reg == ST_OK)
                    begin
                        if (hit)
                        begin
                            offset_reg <= offset_reg + delta_reg[hit_idx];
                            for (int i = 0; i < MAX_DIMS; i++)
                            begin
                                if (IDX_W'(i) == hit_idx)
                                    cnt_reg[i] <= cnt_reg[i] + DIM_WIDTH'(1);
                                else if (IDX_W'(i) > hit_idx)
                                    cnt_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            offset_reg <= '0;
                            cnt_reg    <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // stride tables and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STRIDE && step_reg != '0)
        begin
            stride_reg[ax_idx] <= run_reg;
            span_reg[ax_idx]   <= OFFSET_WIDTH'(prod);
        end
        if (state_reg == S_DELTA && step_reg != '0)
            delta_reg[k_idx] <= stride_reg[k_idx] - suf_reg;
        if (fire)
        begin
            out_value_reg  <= q_value;
            out_status_reg <= err_reg;
            if (err_reg != ST_OK)
            begin
                out_offset_reg <= '0;
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_offset_reg <= offset_reg;
                out_last_reg   <= !hit;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign target_offset = out_offset_reg;
    assign out_value     = out_value_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

endmodule

>>> src/nd_transpose_address_generator_core.sv
// An N-dimensional transpose address generator. Source elements enter one beat
// at a time in row-major order; each leaves with its offset in the transposed
// tensor, its value unchanged, a status code and a last flag on the final beat
// of a pass. The first beat of a pass waits for setup: the configuration is latched
// and checked, strides are built through the shared stride multiplier, and then
// per-axis step deltas are built. After that each beat is a counter step and a
// single add of a precomputed delta, and a new beat is taken while the last one
// waits in the output register unless the output stalls. An error pass takes one
// beat. Configuration is taken on the cfg port at any time, cfg_ready is
// always high, and it only matters when the next pass starts.
// depends on ndt_pkg, ndt_front, ndt_engine, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nd_transpose_address_generator_core
#(
    parameter int MAX_DIMS     = ndt_pkg::DEF_MAX_DIMS,
    parameter int DIM_WIDTH    = ndt_pkg::DEF_DIM_WIDTH,
    parameter int OFFSET_WIDTH = ndt_pkg::DEF_OFFSET_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ndt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ndt_pkg::CFG_SIZE_W-1:0] cfg_data,
    // element input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ndt_pkg::VALUE_W-1:0]    element_value,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [OFFSET_WIDTH-1:0]        target_offset,
    output logic [ndt_pkg::VALUE_W-1:0]    out_value,
    output logic [ndt_pkg::STATUS_W-1:0]   status,
    output logic                           last
);
    import ndt_pkg::*;

    ndt_cfg_t           cfg_reg;
    logic               q_valid;
    logic               q_pop;
    logic [VALUE_W-1:0] q_value;

    // registers are to be written only between passes (the block does not enforce it), so no hold-off is needed
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dims   <= CFG_DIMS_W'(1);
            cfg_reg.dim_size   <= {NUM_CFG_SIZES{CFG_SIZE_W'(1)}};
            cfg_reg.axis_order <= ORDER_W'(228);  // identity order
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_DIMS:   cfg_reg.num_dims    <= cfg_data[CFG_DIMS_W-1:0];
                REG_DIM_SIZE_0: cfg_reg.dim_size[0] <= cfg_data;
                REG_DIM_SIZE_1: cfg_reg.dim_size[1] <= cfg_data;
                REG_DIM_SIZE_2: cfg_reg.dim_size[2] <= cfg_data;
                REG_DIM_SIZE_3: cfg_reg.dim_size[3] <= cfg_data;
                REG_AXIS_ORDER: cfg_reg.axis_order  <= cfg_data[ORDER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // front queue decouples the source from pass setup stalls
    ndt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_value       (q_value)
    );

    // back end does setup, address stepping and holds the result register
    ndt_engine
    #(
        .MAX_DIMS     (MAX_DIMS),
        .DIM_WIDTH    (DIM_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    )
    u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_value       (q_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .target_offset (target_offset),
        .out_value     (out_value),
        .status        (status),
        .last          (last)
    );

    // an error beat closes its pass with offset zero
    `ASSERT_IMPLIES(a_err_closes, clk, rst_n, out_valid && status != ST_OK, last && target_offset == '0)
    // a beat taken mid-pass is followed only by ok beats of the same pass
    `ASSERT_NEXT(a_mid_pass_ok, clk, rst_n, out_valid && !out_stall && !last, !out_valid || status == ST_OK)

endmodule

>>> sim/ndt_result_checker.sv
// result checker for the transpose address generator: tracks config writes,
// predicts each output beat and compares it field by field
// depends on ndt_pkg
`timescale 1ns / 1ps

module ndt_result_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ndt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ndt_pkg::CFG_SIZE_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [63:0]                    element_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [31:0]                    target_offset,
    input  logic [63:0]                    out_value,
    input  logic [1:0]                     status,
    input  logic                           last,
    output int                             fail_count,
    output int                             pending
);
    import ndt_pkg::*;

    typedef struct packed {
        logic [31:0] offset;
        logic [63:0] value;
        logic [1:0]  status;
        logic        last;
    } xpose_beat_t;

    xpose_beat_t beat_queue[$];

    // register copies
    logic [2:0]        reg_dims;
    logic [3:0][15:0]  reg_size;
    logic [7:0]        reg_order;

    // per-pass state
    logic [3:0][15:0]  idx;
    logic [3:0][31:0]  stride;
    logic [3:0][15:0]  lat_size;
    logic [31:0]       acc;
    logic              active;
    logic [1:0]        pass_err;
    int                lat_dims;

    task automatic start_pass();
        int          n;
        logic [1:0]  sel;
        logic [3:0]  seen;
        logic [31:0] run;
        n = (reg_dims > 3'd4) ? 4 : int'(reg_dims);
        for (int i = 0; i < 4; i++)
        begin
            lat_size[i] = (reg_size[i] == 16'd0) ? 16'd1 : reg_size[i];
            idx[i]      = '0;
            stride[i]   = '0;
        end
        lat_dims = n;
        acc      = '0;
        pass_err = ST_OK;
        seen     = '0;
        if (n == 0)
            pass_err = ST_NO_DIMS;
        else
        begin
            for (int j = 0; j < n; j++)
                if (int'(reg_order[2*j +: 2]) >= n)
                    pass_err = ST_AXIS_OOR;
            if (pass_err == ST_OK)
                for (int j = 0; j < n; j++)
                begin
                    sel = reg_order[2*j +: 2];
                    if (seen[sel])
                        pass_err = ST_DUP_AXIS;
                    seen[sel] = 1'b1;
                end
        end
        if (pass_err == ST_OK)
        begin
            // running products from the innermost output axis outward
            run = 32'd1;
            for (int j = n - 1; j >= 0; j--)
            begin
                sel         = reg_order[2*j +: 2];
                stride[sel] = run;
                run         = run * {16'd0, lat_size[sel]};
            end
        end
        active = 1'b1;
    endtask

    task automatic predict_offset(input logic [63:0] v);
        xpose_beat_t e;
        logic        carry;
        if (!active)
            start_pass();
        e.value = v;
        if (pass_err != ST_OK)
        begin
            e.offset = '0;
            e.status = pass_err;
            e.last   = 1'b1;
            active   = 1'b0;
        end
        else
        begin
            e.offset = acc;
            e.status = ST_OK;
            carry    = 1'b1;
            for (int i = lat_dims - 1; i >= 0 && carry; i--)
            begin
                if ({1'b0, idx[i]} + 17'd1 < {1'b0, lat_size[i]})
                begin
                    idx[i] = idx[i] + 16'd1;
                    acc    = acc + stride[i];
                    carry  = 1'b0;
                end
                else
                begin
                    acc    = acc - {16'd0, idx[i]} * stride[i];
                    idx[i] = '0;
                end
            end
            e.last = carry;
            if (carry)
            begin
                active = 1'b0;
                acc    = '0;
            end
        end
        beat_queue.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        xpose_beat_t e;
        if (!rst_n)
        begin
            reg_dims  = 3'd1;
            reg_size  = {4{16'd1}};
            reg_order = 8'd228;
            idx       = '0;
            stride    = '0;
            lat_size  = '0;
            acc       = '0;
            active    = 1'b0;
            pass_err  = ST_OK;
            lat_dims  = 0;
            fail_count = 0;
            beat_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_NUM_DIMS:   reg_dims    = cfg_data[2:0];
                    REG_DIM_SIZE_0: reg_size[0] = cfg_data;
                    REG_DIM_SIZE_1: reg_size[1] = cfg_data;
                    REG_DIM_SIZE_2: reg_size[2] = cfg_data;
                    REG_DIM_SIZE_3: reg_size[3] = cfg_data;
                    REG_AXIS_ORDER: reg_order   = cfg_data[7:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                predict_offset(element_value);
            if (out_valid && !out_stall)
            begin
                if (beat_queue.size() == 0)
                begin
                    $error("output beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = beat_queue.pop_front();
                    if (target_offset !== e.offset)
                    begin
                        $error("target_offset expected %0h actual %0h", e.offset, target_offset);
                        fail_count++;
                    end
                    if (out_value !== e.value)
                    begin
                        $error("out_value expected %0h actual %0h", e.value, out_value);
                        fail_count++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, status);
                        fail_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last expected %0b actual %0b", e.last, last);
                        fail_count++;
                    end
                end
            end
        end
        pending = beat_queue.size();
    end

endmodule

>>> sim/tb_nd_transpose_address_generator_core.sv
// testbench top for the transpose address generator: drives config writes and
// element beats, varies idling on both sides and gives the verdict
// depends on ndt_pkg, nd_transpose_address_generator_core, ndt_result_checker
`timescale 1ns / 1ps

module tb_nd_transpose_address_generator_core;
    import ndt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_NUM_DIMS;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] element_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] target_offset;
    logic [63:0] out_value;
    logic [1:0]  status;
    logic        last;
    int          fail_count;
    int          pending;

    // idle percentages per side, and the long receiver hold-off
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;

    always #5 clk = ~clk;

    nd_transpose_address_generator_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .target_offset(target_offset), .out_value(out_value),
        .status(status), .last(last)
    );

    ndt_result_checker u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .element_value(element_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .target_offset(target_offset), .out_value(out_value),
        .status(status), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver side: random stall, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // one config write; valid stays up for back-to-back writes
    task automatic reg_write(input logic [2:0] idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // full register set, written only once every expected beat has come back
    task automatic load_shape(input logic [15:0] nd, input logic [15:0] s0,
                              input logic [15:0] s1, input logic [15:0] s2,
                              input logic [15:0] s3, input logic [15:0] ord);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        reg_write(REG_NUM_DIMS, nd);
        reg_write(REG_DIM_SIZE_0, s0);
        reg_write(REG_DIM_SIZE_1, s1);
        reg_write(REG_DIM_SIZE_2, s2);
        reg_write(REG_DIM_SIZE_3, s3);
        reg_write(REG_AXIS_ORDER, ord);
        cfg_valid <= 1'b0;
    endtask

    // one element beat, with random gaps ahead of it
    task automatic send_beat(input logic [63:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_many(input int count);
        for (int k = 0; k < count; k++)
            send_beat({$urandom, $urandom});
    endtask

    // random shape: mostly a legal permutation, sometimes junk config
    task automatic random_pass(output int sent);
        int          n;
        int          total;
        logic [15:0] sz[4];
        logic [1:0]  perm[4];
        logic [1:0]  t;
        int          r;
        logic [7:0]  ord;
        n = $urandom_range(1, 4);
        total = 1;
        for (int i = 0; i < 4; i++)
        begin
            // zero extent counts as one
            sz[i] = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
            if (i < n)
                total *= (sz[i] == 0) ? 1 : int'(sz[i]);
            perm[i] = 2'(i);
        end
        for (int i = n - 1; i > 0; i--)
        begin
            r = $urandom_range(i);
            t = perm[i];
            perm[i] = perm[r];
            perm[r] = t;
        end
        ord = {perm[3], perm[2], perm[1], perm[0]};
        if ($urandom_range(99) < 82)
        begin
            // unused register bits carry random junk
            load_shape({13'($urandom), 3'(n)}, sz[0], sz[1], sz[2], sz[3],
                       {8'($urandom), ord});
            sent = total;
        end
        else
        begin
            load_shape(16'($urandom), sz[0], sz[1], sz[2], sz[3], 16'($urandom));
            sent = $urandom_range(1, 4);
        end
        send_many(sent);
    endtask

    task automatic random_phase(input int beats);
        int start_count;
        int sent;
        start_count = 0;
        while (start_count < beats)
        begin
            random_pass(sent);
            start_count += sent;
        end
    endtask

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset config is one dim of extent one
        send_many(2);
        // no dimensions
        load_shape(16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd228);
        send_beat('0);
        send_beat('1);
        // axis out of range: output axis 1 names source axis 3
        load_shape(16'd2, 16'd2, 16'd2, 16'd1, 16'd1, 16'h000C);
        send_many(1);
        // duplicate axis
        load_shape(16'd2, 16'd2, 16'd2, 16'd1, 16'd1, 16'h0000);
        send_many(1);
        // zero extent in use, and a 2x3 swap
        load_shape(16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd228);
        send_many(1);
        load_shape(16'd2, 16'd2, 16'd3, 16'd1, 16'd1, 16'h00E1);
        send_many(6);
        // dim count above the limit saturates, full reversal
        load_shape(16'd7, 16'd2, 16'd2, 16'd2, 16'd1, 16'h001B);
        send_many(8);

        // long receiver hold-off while the sender keeps offering beats
        load_shape(16'd3, 16'd4, 16'd4, 16'd4, 16'd1, 16'h00D2);
        @(negedge clk);
        hold_cycles <= 150;
        send_many(64);

        send_idle = 38;
        recv_idle = 53;
        random_phase(450);
        send_idle = 53;
        recv_idle = 38;
        random_phase(450);
        send_idle = 0;
        recv_idle = 0;
        random_phase(450);

        // largest extents, offsets wrap; the pass is left unfinished
        load_shape(16'd4, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFF, 16'h004E);
        send_many(40);
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
